// ----- rtl/core/sdcal_pkg.sv -----
// Shared widths, calendar constants and the month table for the serial date converter.
package sdcal_pkg;

    localparam int FRACTION_BITS_DEF = 24;

    localparam int MAG_W  = 48;
    localparam int DAY_W  = 22;
    localparam int SEC_W  = 17;
    localparam int MIN_W  = 11;
    localparam int YBLK_W = 16;

    localparam logic [DAY_W-1:0] MAX_DAYS      = 22'd2958465;
    localparam logic [DAY_W-1:0] MIN_DAYS      = 22'd657434;
    localparam logic [DAY_W-1:0] DAYS_TO_EPOCH = 22'd693959;

    localparam int unsigned DAYS_400Y    = 146097;
    localparam int unsigned DAYS_100Y    = 36524;
    localparam int unsigned DAYS_4Y      = 1461;
    localparam int unsigned DAYS_1Y      = 365;
    localparam int unsigned DAYS_WEEK    = 7;
    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned SECS_PER_MIN = 60;
    localparam int unsigned MINS_PER_HR  = 60;

    localparam int unsigned YEARS_400 = 400;
    localparam int unsigned YEARS_100 = 100;
    localparam int unsigned YEARS_4   = 4;

    localparam logic [8:0] LEAP_DAY_INDEX = 9'd59;
    localparam logic [3:0] MONTH_FEB      = 4'd2;
    localparam logic [4:0] LEAP_DAY_MDAY  = 5'd29;

    // Days before the start of each month in a common year.
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            4'd12:   d = 9'd365;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/core/serial_date_to_calendar_fields_core.sv -----
// Pipelined converter from a fixed-point serial date to calendar fields and time of day.
//
// The block takes one item in every clock cycle and never stalls: busy is held low, and each
// item accepted with start high gives exactly one result, shown with done high for one cycle
// once it has passed the ten register ranks of the pipeline. Every division by 400 years, a
// week, a minute, an hour or four years is a reciprocal multiplication followed, one rank
// later, by a single compare and subtract. The receiver must take every result in the cycle
// it appears. Inputs outside the supported day range give valid_res low and every field zero.
module serial_date_to_calendar_fields_core import sdcal_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [MAG_W-1:0] serial_date,
    output logic                    done,
    output logic                    valid_res,
    output logic [13:0]             year,
    output logic [3:0]              month,
    output logic [4:0]              day_of_month,
    output logic [2:0]              weekday,
    output logic [8:0]              day_of_year,
    output logic [4:0]              hour,
    output logic [5:0]              minute,
    output logic [5:0]              second
);

    // The range limits are compared in a width that holds both the magnitude and the
    // largest limit shifted up by the fraction bits.
    localparam int CMP_W  = (DAY_W + FRACTION_BITS > MAG_W) ? DAY_W + FRACTION_BITS : MAG_W;
    localparam int PROD_W = FRACTION_BITS + SEC_W;

    localparam logic [CMP_W-1:0] HI_LIM = CMP_W'({MAX_DAYS, {FRACTION_BITS{1'b0}}});
    localparam logic [CMP_W-1:0] LO_LIM = CMP_W'({MIN_DAYS, {FRACTION_BITS{1'b0}}});

    // Half a second in fraction units, rounded to nearest.
    localparam longint unsigned HALF_UNITS =
        ((64'd1 << FRACTION_BITS) + 64'(SECS_PER_DAY)) / (64'(SECS_PER_DAY) * 64'd2);
    localparam logic [CMP_W:0] HALF_EXT = (CMP_W + 1)'(HALF_UNITS);

    // Reciprocals scaled by two to the power of the dividend width. The estimate they give
    // is at most one below the true quotient, so one correction step finishes the division.
    localparam logic [DAY_W-1:0]  RCP_400Y = DAY_W'((1 << DAY_W) / DAYS_400Y);
    localparam logic [DAY_W-1:0]  RCP_WEEK = DAY_W'((1 << DAY_W) / DAYS_WEEK);
    localparam logic [SEC_W-1:0]  RCP_SMIN = SEC_W'((1 << SEC_W) / SECS_PER_MIN);
    localparam logic [MIN_W-1:0]  RCP_MHR  = MIN_W'((1 << MIN_W) / MINS_PER_HR);
    localparam logic [YBLK_W-1:0] RCP_4Y   = YBLK_W'((1 << YBLK_W) / DAYS_4Y);

    // The receiver cannot stall, so the pipeline always advances.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage registers. Valid bits are reset; payload is not.
    // ------------------------------------------------------------------
    logic                     s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    logic                     s6_v_reg, s7_v_reg, s8_v_reg, s9_v_reg, done_reg;

    logic                     s1_neg_reg, s1_neg_next;
    logic [MAG_W-1:0]         s1_mag_reg, s1_mag_next;

    logic                     s2_ok_reg, s2_ok_next;
    logic                     s2_neg_reg;
    logic [DAY_W-1:0]         s2_whole_reg, s2_whole_next;
    logic [FRACTION_BITS-1:0] s2_frac_reg, s2_frac_next;

    logic                     s3_ok_reg;
    logic [DAY_W-1:0]         s3_days_reg, s3_days_next;
    logic [PROD_W-1:0]        s3_sprod_reg, s3_sprod_next;

    logic                     s4_ok_reg;
    logic [DAY_W-1:0]         s4_days_reg;
    logic [DAY_W-1:0]         s4_q400e_reg, s4_q400e_next;
    logic [DAY_W-1:0]         s4_q7e_reg, s4_q7e_next;
    logic [SEC_W-1:0]         s4_secs_reg, s4_secs_next;
    logic [SEC_W-1:0]         s4_qs60e_reg, s4_qs60e_next;

    logic                     s5_ok_reg;
    logic [4:0]               s5_n400_reg, s5_n400_next;
    logic [17:0]              s5_r400_reg, s5_r400_next;
    logic [2:0]               s5_wday_reg, s5_wday_next;
    logic [MIN_W-1:0]         s5_mins_reg, s5_mins_next;
    logic [5:0]               s5_sec_reg, s5_sec_next;

    logic                     s6_ok_reg;
    logic [4:0]               s6_n400_reg;
    logic [1:0]               s6_cent_reg, s6_cent_next;
    logic [YBLK_W-1:0]        s6_y_reg, s6_y_next;
    logic [2:0]               s6_wday_reg;
    logic [MIN_W-1:0]         s6_mins_reg;
    logic [MIN_W-1:0]         s6_qhe_reg, s6_qhe_next;
    logic [5:0]               s6_sec_reg;

    logic                     s7_ok_reg;
    logic [4:0]               s7_n400_reg;
    logic [1:0]               s7_cent_reg;
    logic [YBLK_W-1:0]        s7_y_reg;
    logic [YBLK_W-1:0]        s7_q4e_reg, s7_q4e_next;
    logic [2:0]               s7_wday_reg;
    logic [4:0]               s7_hour_reg, s7_hour_next;
    logic [5:0]               s7_min_reg, s7_min_next;
    logic [5:0]               s7_sec_reg;

    logic                     s8_ok_reg;
    logic [4:0]               s8_n400_reg;
    logic [1:0]               s8_cent_reg;
    logic [4:0]               s8_n4_reg, s8_n4_next;
    logic [10:0]              s8_d4_reg, s8_d4_next;
    logic                     s8_leap4_reg, s8_leap4_next;
    logic [2:0]               s8_wday_reg;
    logic [4:0]               s8_hour_reg;
    logic [5:0]               s8_min_reg;
    logic [5:0]               s8_sec_reg;

    logic                     s9_ok_reg;
    logic [13:0]              s9_year_reg, s9_year_next;
    logic [8:0]               s9_d4_reg, s9_d4_next;
    logic                     s9_leap0_reg, s9_leap0_next;
    logic [8:0]               s9_yday_reg, s9_yday_next;
    logic [2:0]               s9_wday_reg;
    logic [4:0]               s9_hour_reg;
    logic [5:0]               s9_min_reg;
    logic [5:0]               s9_sec_reg;

    logic                     valid_res_reg;
    logic [13:0]              year_reg;
    logic [3:0]               month_reg, month_next;
    logic [4:0]               mday_reg, mday_next;
    logic [2:0]               wday_reg;
    logic [8:0]               yday_reg;
    logic [4:0]               hour_reg;
    logic [5:0]               minute_reg;
    logic [5:0]               second_reg;

    // ------------------------------------------------------------------
    // Stage 1: sign and magnitude of the input.
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_neg_next = serial_date[MAG_W-1];
        s1_mag_next = s1_neg_next ? (~serial_date + MAG_W'(1)) : serial_date;
    end

    // ------------------------------------------------------------------
    // Stage 2: range check and rounding to the second. Both work on the
    // same magnitude in parallel. A magnitude past the limit for its sign
    // marks the item as out of range; its fields are cleared at the end.
    // ------------------------------------------------------------------
    logic [CMP_W-1:0] s2_mag_ext;
    logic [CMP_W:0]   s2_sum;

    always_comb
    begin
        s2_mag_ext    = CMP_W'(s1_mag_reg);
        s2_ok_next    = s1_neg_reg ? (s2_mag_ext <= LO_LIM) : (s2_mag_ext <= HI_LIM);
        s2_sum        = {1'b0, s2_mag_ext} + HALF_EXT;
        s2_whole_next = s2_sum[FRACTION_BITS +: DAY_W];
        s2_frac_next  = s2_sum[FRACTION_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 3: absolute day count from the epoch offset, and the fraction
    // scaled to seconds. A negative date counts back from the epoch while
    // its fraction is still read forward as the time of day.
    // ------------------------------------------------------------------
    always_comb
    begin
        s3_days_next  = s2_neg_reg ? (DAYS_TO_EPOCH - s2_whole_reg)
                                   : (DAYS_TO_EPOCH + s2_whole_reg);
        s3_sprod_next = PROD_W'(s2_frac_reg) * PROD_W'(SECS_PER_DAY);
    end

    // ------------------------------------------------------------------
    // Stage 4: quotient estimates for the 400-year split, the weekday and
    // the minutes of the day.
    // ------------------------------------------------------------------
    logic [2*DAY_W-1:0] s4_p400, s4_p7;
    logic [2*SEC_W-1:0] s4_ps60;
    logic [DAY_W-1:0]   s4_x7;

    always_comb
    begin
        s4_x7         = s3_days_reg - DAY_W'(1);
        s4_secs_next  = s3_sprod_reg[FRACTION_BITS +: SEC_W];
        s4_p400       = (2*DAY_W)'(s3_days_reg) * (2*DAY_W)'(RCP_400Y);
        s4_p7         = (2*DAY_W)'(s4_x7) * (2*DAY_W)'(RCP_WEEK);
        s4_ps60       = (2*SEC_W)'(s4_secs_next) * (2*SEC_W)'(RCP_SMIN);
        s4_q400e_next = s4_p400[2*DAY_W-1:DAY_W];
        s4_q7e_next   = s4_p7[2*DAY_W-1:DAY_W];
        s4_qs60e_next = s4_ps60[2*SEC_W-1:SEC_W];
    end

    // ------------------------------------------------------------------
    // Stage 5: correction steps. Each remainder is below twice its divisor.
    // ------------------------------------------------------------------
    logic [DAY_W-1:0] s5_r400e, s5_r400c, s5_x7, s5_r7e, s5_r7c;
    logic [SEC_W-1:0] s5_rs60e, s5_rs60c, s5_mins_full;
    logic [DAY_W-1:0] s5_n400_full;

    always_comb
    begin
        s5_r400e = s4_days_reg - (s4_q400e_reg * DAY_W'(DAYS_400Y));
        if (s5_r400e >= DAY_W'(DAYS_400Y))
        begin
            s5_r400c     = s5_r400e - DAY_W'(DAYS_400Y);
            s5_n400_full = s4_q400e_reg + DAY_W'(1);
        end
        else
        begin
            s5_r400c     = s5_r400e;
            s5_n400_full = s4_q400e_reg;
        end
        s5_n400_next = s5_n400_full[4:0];
        s5_r400_next = s5_r400c[17:0];

        s5_x7  = s4_days_reg - DAY_W'(1);
        s5_r7e = s5_x7 - (s4_q7e_reg * DAY_W'(DAYS_WEEK));
        s5_r7c = (s5_r7e >= DAY_W'(DAYS_WEEK)) ? (s5_r7e - DAY_W'(DAYS_WEEK)) : s5_r7e;
        s5_wday_next = s5_r7c[2:0] + 3'd1;

        s5_rs60e = s4_secs_reg - (s4_qs60e_reg * SEC_W'(SECS_PER_MIN));
        if (s5_rs60e >= SEC_W'(SECS_PER_MIN))
        begin
            s5_rs60c     = s5_rs60e - SEC_W'(SECS_PER_MIN);
            s5_mins_full = s4_qs60e_reg + SEC_W'(1);
        end
        else
        begin
            s5_rs60c     = s5_rs60e;
            s5_mins_full = s4_qs60e_reg;
        end
        s5_mins_next = s5_mins_full[MIN_W-1:0];
        s5_sec_next  = s5_rs60c[5:0];
    end

    // ------------------------------------------------------------------
    // Stage 6: century within the 400-year block. A zero day falls in the
    // first century. The day within the block that the 4-year split works
    // on comes either straight from the 400-year remainder or from the day
    // within the century plus one; both stay below 16 bits.
    // ------------------------------------------------------------------
    logic [17:0]        s6_rm1, s6_dc_full;
    logic [YBLK_W-1:0]  s6_dc;
    logic [2*MIN_W-1:0] s6_ph;

    always_comb
    begin
        s6_rm1 = s5_r400_reg - 18'd1;
        if (s5_r400_reg == 18'd0)
            s6_cent_next = 2'd0;
        else if (s6_rm1 >= 18'(3 * DAYS_100Y))
            s6_cent_next = 2'd3;
        else if (s6_rm1 >= 18'(2 * DAYS_100Y))
            s6_cent_next = 2'd2;
        else if (s6_rm1 >= 18'(DAYS_100Y))
            s6_cent_next = 2'd1;
        else
            s6_cent_next = 2'd0;
        s6_dc_full = s6_rm1 - (18'(s6_cent_next) * 18'(DAYS_100Y));
        s6_dc      = s6_dc_full[YBLK_W-1:0];
        s6_y_next  = (s6_cent_next == 2'd0) ? s5_r400_reg[YBLK_W-1:0] : (s6_dc + YBLK_W'(1));

        s6_ph       = (2*MIN_W)'(s5_mins_reg) * (2*MIN_W)'(RCP_MHR);
        s6_qhe_next = s6_ph[2*MIN_W-1:MIN_W];
    end

    // ------------------------------------------------------------------
    // Stage 7: estimate of the 4-year block, and hour and minute.
    // ------------------------------------------------------------------
    logic [2*YBLK_W-1:0] s7_p4;
    logic [MIN_W-1:0]    s7_rhe, s7_rhc, s7_hour_full;

    always_comb
    begin
        s7_p4       = (2*YBLK_W)'(s6_y_reg) * (2*YBLK_W)'(RCP_4Y);
        s7_q4e_next = s7_p4[2*YBLK_W-1:YBLK_W];

        s7_rhe = s6_mins_reg - (s6_qhe_reg * MIN_W'(MINS_PER_HR));
        if (s7_rhe >= MIN_W'(MINS_PER_HR))
        begin
            s7_rhc       = s7_rhe - MIN_W'(MINS_PER_HR);
            s7_hour_full = s6_qhe_reg + MIN_W'(1);
        end
        else
        begin
            s7_rhc       = s7_rhe;
            s7_hour_full = s6_qhe_reg;
        end
        s7_hour_next = s7_hour_full[4:0];
        s7_min_next  = s7_rhc[5:0];
    end

    // ------------------------------------------------------------------
    // Stage 8: 4-year block and day within it. The first 4-year block of a
    // century other than the first has no leap day; there the day is the
    // day within the century itself.
    // ------------------------------------------------------------------
    logic [YBLK_W-1:0] s8_r4e, s8_r4c, s8_n4_full;

    always_comb
    begin
        s8_r4e = s7_y_reg - (s7_q4e_reg * YBLK_W'(DAYS_4Y));
        if (s8_r4e >= YBLK_W'(DAYS_4Y))
        begin
            s8_r4c     = s8_r4e - YBLK_W'(DAYS_4Y);
            s8_n4_full = s7_q4e_reg + YBLK_W'(1);
        end
        else
        begin
            s8_r4c     = s8_r4e;
            s8_n4_full = s7_q4e_reg;
        end
        s8_n4_next    = s8_n4_full[4:0];
        s8_leap4_next = !((s7_cent_reg != 2'd0) && (s8_n4_next == 5'd0));
        s8_d4_next    = s8_leap4_next ? s8_r4c[10:0] : (s8_r4c[10:0] - 11'd1);
    end

    // ------------------------------------------------------------------
    // Stage 9: year within the 4-year block, day of year and full year.
    // In a block with a leap year the first year is 366 days long; a zero
    // day stays in that year.
    // ------------------------------------------------------------------
    logic [10:0] s9_z, s9_rem_full;
    logic [1:0]  s9_yrc, s9_yr;
    logic [8:0]  s9_rem;

    always_comb
    begin
        s9_z = s8_leap4_reg ? (s8_d4_reg - 11'd1) : s8_d4_reg;
        if (s9_z >= 11'(3 * DAYS_1Y))
            s9_yrc = 2'd3;
        else if (s9_z >= 11'(2 * DAYS_1Y))
            s9_yrc = 2'd2;
        else if (s9_z >= 11'(DAYS_1Y))
            s9_yrc = 2'd1;
        else
            s9_yrc = 2'd0;
        s9_rem_full = s9_z - (11'(s9_yrc) * 11'(DAYS_1Y));
        s9_rem      = s9_rem_full[8:0];

        if (s8_leap4_reg && (s8_d4_reg == 11'd0))
        begin
            s9_yr      = 2'd0;
            s9_d4_next = 9'd0;
        end
        else if (s8_leap4_reg && (s9_yrc == 2'd0))
        begin
            s9_yr      = 2'd0;
            s9_d4_next = s8_d4_reg[8:0];
        end
        else
        begin
            s9_yr      = s9_yrc;
            s9_d4_next = s9_rem;
        end

        s9_leap0_next = s8_leap4_reg && (s9_yr == 2'd0);
        s9_yday_next  = s9_d4_next + 9'd1;
        s9_year_next  = (14'(s8_n400_reg) * 14'(YEARS_400))
                      + (14'(s8_cent_reg) * 14'(YEARS_100))
                      + (14'(s8_n4_reg) * 14'(YEARS_4))
                      + 14'(s9_yr);
    end

    // ------------------------------------------------------------------
    // Stage 10: month and day of month. February 29 is taken directly;
    // later days of a leap year are moved back one so the common-year table
    // serves. The month is one more than the number of month ends that the
    // one-based day lies beyond.
    // ------------------------------------------------------------------
    logic [8:0] s10_dm, s10_dm1, s10_mday_full;
    logic [3:0] s10_cnt;

    always_comb
    begin
        s10_dm  = (s9_leap0_reg && (s9_d4_reg > LEAP_DAY_INDEX)) ? (s9_d4_reg - 9'd1)
                                                                 : s9_d4_reg;
        s10_dm1 = s10_dm + 9'd1;
        s10_cnt = 4'd0;
        for (int m = 1; m < 12; m++)
        begin
            if (s10_dm1 > cum_days(4'(m)))
                s10_cnt = s10_cnt + 4'd1;
        end
        s10_mday_full = s10_dm1 - cum_days(s10_cnt);

        if (s9_leap0_reg && (s9_d4_reg == LEAP_DAY_INDEX))
        begin
            month_next = MONTH_FEB;
            mday_next  = LEAP_DAY_MDAY;
        end
        else
        begin
            month_next = s10_cnt + 4'd1;
            mday_next  = s10_mday_full[4:0];
        end
    end

    // ------------------------------------------------------------------
    // Valid bits.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
            s8_v_reg <= 1'b0;
            s9_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= start && !busy;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
            s7_v_reg <= s6_v_reg;
            s8_v_reg <= s7_v_reg;
            s9_v_reg <= s8_v_reg;
            done_reg <= s9_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers. They move every cycle; a rank whose valid bit is
    // low simply carries data that nobody looks at.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        s1_neg_reg    <= s1_neg_next;
        s1_mag_reg    <= s1_mag_next;

        s2_ok_reg     <= s2_ok_next;
        s2_neg_reg    <= s1_neg_reg;
        s2_whole_reg  <= s2_whole_next;
        s2_frac_reg   <= s2_frac_next;

        s3_ok_reg     <= s2_ok_reg;
        s3_days_reg   <= s3_days_next;
        s3_sprod_reg  <= s3_sprod_next;

        s4_ok_reg     <= s3_ok_reg;
        s4_days_reg   <= s3_days_reg;
        s4_q400e_reg  <= s4_q400e_next;
        s4_q7e_reg    <= s4_q7e_next;
        s4_secs_reg   <= s4_secs_next;
        s4_qs60e_reg  <= s4_qs60e_next;

        s5_ok_reg     <= s4_ok_reg;
        s5_n400_reg   <= s5_n400_next;
        s5_r400_reg   <= s5_r400_next;
        s5_wday_reg   <= s5_wday_next;
        s5_mins_reg   <= s5_mins_next;
        s5_sec_reg    <= s5_sec_next;

        s6_ok_reg     <= s5_ok_reg;
        s6_n400_reg   <= s5_n400_reg;
        s6_cent_reg   <= s6_cent_next;
        s6_y_reg      <= s6_y_next;
        s6_wday_reg   <= s5_wday_reg;
        s6_mins_reg   <= s5_mins_reg;
        s6_qhe_reg    <= s6_qhe_next;
        s6_sec_reg    <= s5_sec_reg;

        s7_ok_reg     <= s6_ok_reg;
        s7_n400_reg   <= s6_n400_reg;
        s7_cent_reg   <= s6_cent_reg;
        s7_y_reg      <= s6_y_reg;
        s7_q4e_reg    <= s7_q4e_next;
        s7_wday_reg   <= s6_wday_reg;
        s7_hour_reg   <= s7_hour_next;
        s7_min_reg    <= s7_min_next;
        s7_sec_reg    <= s6_sec_reg;

        s8_ok_reg     <= s7_ok_reg;
        s8_n400_reg   <= s7_n400_reg;
        s8_cent_reg   <= s7_cent_reg;
        s8_n4_reg     <= s8_n4_next;
        s8_d4_reg     <= s8_d4_next;
        s8_leap4_reg  <= s8_leap4_next;
        s8_wday_reg   <= s7_wday_reg;
        s8_hour_reg   <= s7_hour_reg;
        s8_min_reg    <= s7_min_reg;
        s8_sec_reg    <= s7_sec_reg;

        s9_ok_reg     <= s8_ok_reg;
        s9_year_reg   <= s9_year_next;
        s9_d4_reg     <= s9_d4_next;
        s9_leap0_reg  <= s9_leap0_next;
        s9_yday_reg   <= s9_yday_next;
        s9_wday_reg   <= s8_wday_reg;
        s9_hour_reg   <= s8_hour_reg;
        s9_min_reg    <= s8_min_reg;
        s9_sec_reg    <= s8_sec_reg;

        // An out-of-range item leaves with every field cleared.
        valid_res_reg <= s9_ok_reg;
        year_reg      <= s9_ok_reg ? s9_year_reg : 14'd0;
        month_reg     <= s9_ok_reg ? month_next  : 4'd0;
        mday_reg      <= s9_ok_reg ? mday_next   : 5'd0;
        wday_reg      <= s9_ok_reg ? s9_wday_reg : 3'd0;
        yday_reg      <= s9_ok_reg ? s9_yday_reg : 9'd0;
        hour_reg      <= s9_ok_reg ? s9_hour_reg : 5'd0;
        minute_reg    <= s9_ok_reg ? s9_min_reg  : 6'd0;
        second_reg    <= s9_ok_reg ? s9_sec_reg  : 6'd0;
    end

    assign done         = done_reg;
    assign valid_res    = valid_res_reg;
    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = mday_reg;
    assign weekday      = wday_reg;
    assign day_of_year  = yday_reg;
    assign hour         = hour_reg;
    assign minute       = minute_reg;
    assign second       = second_reg;

endmodule

// ----- rtl/core/sdcal_checker.sv -----
// Port-level checks on the serial date converter and the bind that attaches them.
module sdcal_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [47:0] serial_date,
    input logic        done,
    input logic        valid_res,
    input logic [13:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day_of_month,
    input logic [2:0]  weekday,
    input logic [8:0]  day_of_year,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second
);

    localparam int LATENCY = 10;

    // Every accepted item leaves after the fixed latency.
    a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item gave no result");

    // No result appears without an item accepted the latency earlier.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted item");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !valid_res) |-> (year == 14'd0 && month == 4'd0 && day_of_month == 5'd0 &&
                                  weekday == 3'd0 && day_of_year == 9'd0 && hour == 5'd0 &&
                                  minute == 6'd0 && second == 6'd0))
        else $error("out-of-range item with non-zero fields");

    a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (done && valid_res) |-> (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1 &&
                                 weekday >= 3'd1 && day_of_year >= 9'd1 &&
                                 day_of_year <= 9'd366 && hour <= 5'd23 &&
                                 minute <= 6'd59 && second <= 6'd59))
        else $error("calendar field outside its range");

endmodule

bind serial_date_to_calendar_fields_core sdcal_checker u_sdcal_checker (.*);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the serial date to calendar fields converter.
module tb_top import sdcal_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Fixed-point layout of the serial date, as the block is built with its default width.
    localparam int          FB        = FRACTION_BITS_DEF;
    localparam logic [63:0] FMASK     = (64'd1 << FB) - 64'd1;
    localparam logic [63:0] HALF_DAY  = 64'd1 << (FB - 1);
    localparam logic [63:0] ROUND_ADD = ((64'd1 << FB) + 64'd86400) / 64'd172800;
    localparam logic [63:0] LO_LIMIT  = {42'd0, MIN_DAYS} << FB;
    localparam logic [63:0] HI_LIMIT  = {42'd0, MAX_DAYS} << FB;
    localparam longint      EPOCH_ABS = longint'(DAYS_TO_EPOCH);

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 30;
    localparam int RANDOM_DATES  = 530;
    localparam int REPORT_LIMIT  = 10;

    // Weekday and month codes used by the hand-written expectations.
    localparam logic [2:0] FRIDAY   = 3'd6;
    localparam logic [2:0] SATURDAY = 3'd7;
    localparam logic [3:0] JANUARY  = 4'd1;
    localparam logic [3:0] DECEMBER = 4'd12;

    // Days before the first of each month in a common year, January at index 0.
    localparam logic [12:0][8:0] MONTH_START = {
        9'd365, 9'd334, 9'd304, 9'd273, 9'd243, 9'd212, 9'd181,
        9'd151, 9'd120, 9'd90,  9'd59,  9'd31,  9'd0
    };

    typedef struct packed {
        logic        valid;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [2:0]  wday;
        logic [8:0]  yday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_fields_t;

    // One outstanding conversion: the date that went in and the fields it must give.
    typedef struct packed {
        logic [47:0] sd;
        cal_fields_t fields;
    } pending_date_t;

    // One row of the directed table. Where lit_on is set, lit holds the fields typed in by
    // hand; otherwise the row is checked against the predictor.
    typedef struct packed {
        logic [47:0] sd;
        logic        lit_on;
        cal_fields_t lit;
    } date_row_t;

    localparam cal_fields_t NO_DATE = '0;
    // Zero input: rounding only nudges the magnitude, so midnight on the epoch day.
    localparam cal_fields_t EPOCH_DATE =
        {1'b1, 14'd1899, DECEMBER, 5'd30, SATURDAY, 9'd364, 5'd0, 6'd0, 6'd0};
    // Upper limit exactly: the last day of year 9999, a Friday.
    localparam cal_fields_t LAST_DATE =
        {1'b1, 14'd9999, DECEMBER, 5'd31, FRIDAY, 9'd365, 5'd0, 6'd0, 6'd0};
    // Lower limit exactly: the first day of year 100, also a Friday.
    localparam cal_fields_t FIRST_DATE =
        {1'b1, 14'd100, JANUARY, 5'd1, FRIDAY, 9'd1, 5'd0, 6'd0, 6'd0};

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [47:0] serial_date;
    logic               done;
    logic               valid_res;
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day_of_month;
    logic [2:0]         weekday;
    logic [8:0]         day_of_year;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;

    serial_date_to_calendar_fields_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .serial_date  (serial_date),
        .done         (done),
        .valid_res    (valid_res),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .weekday      (weekday),
        .day_of_year  (day_of_year),
        .hour         (hour),
        .minute       (minute),
        .second       (second)
    );

    // Conversions accepted by the block whose results have not yet come out, oldest first.
    pending_date_t pending_dates[$];

    int          issued_dates;
    int          accepted_dates;
    int          checked_dates;
    int          in_range_dates;
    int          rejected_dates;
    int          leap_days_seen;
    int          mismatches;
    int          cycles;
    int          burst_left;
    logic        use_literal;
    cal_fields_t literal_fields;

    // Builds a serial date from a sign, whole days and a fraction of a day. For a negative
    // date the fraction is part of the magnitude, exactly as the block reads it.
    function automatic logic [47:0] serial_of(input logic neg, input logic [63:0] days,
                                              input logic [63:0] frac);
        logic [47:0] m;
        m = 48'((days << FB) | (frac & FMASK));
        return neg ? (~m + 48'd1) : m;
    endfunction

    // Predicts the calendar fields for one serial date.
    function automatic cal_fields_t calendar_of(input logic [47:0] sd);
        cal_fields_t f;
        logic        neg;
        logic        leap_block;
        logic [47:0] m48;
        logic [63:0] mag, whole, frac, secs, absd, r, dc;
        logic [63:0] n400, cent, n4, yr, d4, mon, mday;
        f   = NO_DATE;
        neg = sd[47];
        m48 = neg ? (~sd + 48'd1) : sd;
        mag = {16'd0, m48};
        if (neg ? (mag > LO_LIMIT) : (mag > HI_LIMIT))
            return f;

        // Round to the nearest second, then split into whole days and seconds of the day.
        mag   = mag + ROUND_ADD;
        whole = mag >> FB;
        frac  = mag & FMASK;
        secs  = (frac * 64'd86400) >> FB;
        absd  = neg ? ({42'd0, DAYS_TO_EPOCH} - whole) : ({42'd0, DAYS_TO_EPOCH} + whole);

        // Gregorian cycles: 400 years, then centuries, then four-year blocks, then years.
        leap_block = 1'b1;
        n400 = absd / 64'd146097;
        r    = absd % 64'd146097;
        cent = (r == 0) ? 64'd0 : (r - 64'd1) / 64'd36524;
        if (cent != 0)
        begin
            dc = (r - 64'd1) % 64'd36524;
            n4 = (dc + 64'd1) / 64'd1461;
            if (n4 != 0)
                d4 = (dc + 64'd1) % 64'd1461;
            else
            begin
                // The first four years of a non-leap century have no leap day.
                leap_block = 1'b0;
                d4 = dc;
            end
        end
        else
        begin
            n4 = r / 64'd1461;
            d4 = r % 64'd1461;
        end

        if (leap_block)
        begin
            if (d4 == 0)
                yr = 0;
            else
            begin
                yr = (d4 - 64'd1) / 64'd365;
                if (yr != 0)
                    d4 = (d4 - 64'd1) % 64'd365;
            end
        end
        else
        begin
            yr = d4 / 64'd365;
            d4 = d4 % 64'd365;
        end

        f.valid = 1'b1;
        f.yday  = 9'(d4 + 64'd1);
        f.year  = 14'(n400 * 64'd400 + cent * 64'd100 + n4 * 64'd4 + yr);

        if (yr == 0 && leap_block && d4 == 64'd59)
        begin
            mon  = 64'(MONTH_FEB);
            mday = 64'(LEAP_DAY_MDAY);
        end
        else
        begin
            // Past the leap day the month table of a common year applies one day earlier.
            if (yr == 0 && leap_block && d4 >= 64'd60)
                d4 = d4 - 64'd1;
            d4  = d4 + 64'd1;
            mon = (d4 >> 5) + 64'd1;
            while (mon < 64'd12 && d4 > 64'(MONTH_START[mon]))
                mon = mon + 64'd1;
            mday = d4 - 64'(MONTH_START[mon - 64'd1]);
        end

        f.month  = 4'(mon);
        f.mday   = 5'(mday);
        f.wday   = 3'(((absd - 64'd1) % 64'd7) + 64'd1);
        f.hour   = 5'(secs / 64'd3600);
        f.minute = 6'((secs / 64'd60) % 64'd60);
        f.second = 6'(secs % 64'd60);
        return f;
    endfunction

    // Presents one date and returns at the falling edge after it has been accepted. The sender
    // works in bursts: when a burst runs out, start drops for a random gap, which may be zero,
    // and a new burst length is drawn. Some bursts are long, giving stretches without any idling.
    task automatic send_date(input logic [47:0] sd, input logic lit_on, input cal_fields_t lit);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
        end
        start          <= 1'b1;
        serial_date    <= sd;
        use_literal     = lit_on;
        literal_fields  = lit;
        issued_dates++;
        burst_left--;
        do
            @(negedge clk);
        while (accepted_dates != issued_dates);
    endtask

    // Free-running clock, 20 ns period.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Cycle counter: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, pending_dates.size());
            $display("FAIL");
            $finish;
        end
    end

    // Acceptance and checking. Both are sampled at the rising edge, before the block's own
    // registers update, so the values seen are those of the cycle that the edge ends.
    always @(posedge clk)
    begin : monitor
        pending_date_t entry;
        pending_date_t oldest;
        cal_fields_t   got;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                entry.sd     = serial_date;
                entry.fields = use_literal ? literal_fields : calendar_of(serial_date);
                pending_dates.push_back(entry);
                accepted_dates++;
            end

            if (done)
            begin
                got = {valid_res, year, month, day_of_month, weekday, day_of_year,
                       hour, minute, second};
                if (pending_dates.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("Result with no date outstanding: valid=%0d %0d-%0d-%0d",
                                 got.valid, got.year, got.month, got.mday);
                end
                else
                begin
                    oldest = pending_dates.pop_front();
                    checked_dates++;
                    if (oldest.fields.valid)
                        in_range_dates++;
                    else
                        rejected_dates++;
                    if (oldest.fields.month == MONTH_FEB && oldest.fields.mday == LEAP_DAY_MDAY)
                        leap_days_seen++;
                    if (got.valid  !== oldest.fields.valid  || got.year   !== oldest.fields.year
                     || got.month  !== oldest.fields.month  || got.mday   !== oldest.fields.mday
                     || got.wday   !== oldest.fields.wday   || got.yday   !== oldest.fields.yday
                     || got.hour   !== oldest.fields.hour   || got.minute !== oldest.fields.minute
                     || got.second !== oldest.fields.second)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("Mismatch for date %h:", oldest.sd);
                            $display("  expected v=%0d %0d-%0d-%0d wd=%0d yd=%0d %0d:%0d:%0d",
                                     oldest.fields.valid, oldest.fields.year,
                                     oldest.fields.month, oldest.fields.mday,
                                     oldest.fields.wday, oldest.fields.yday,
                                     oldest.fields.hour, oldest.fields.minute,
                                     oldest.fields.second);
                            $display("  actual   v=%0d %0d-%0d-%0d wd=%0d yd=%0d %0d:%0d:%0d",
                                     got.valid, got.year, got.month, got.mday, got.wday,
                                     got.yday, got.hour, got.minute, got.second);
                        end
                    end
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then random dates, then drain and verdict.
    initial
    begin : stimulus
        date_row_t   directed[$];
        logic [47:0] sd;
        logic [63:0] wide;
        logic [63:0] days;
        logic [63:0] frac;
        longint      signed_days;
        logic        neg;
        int          i;
        int          kind;

        start          = 1'b0;
        serial_date    = '0;
        use_literal    = 1'b0;
        literal_fields = NO_DATE;
        burst_left     = 0;
        rst_n          = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extremes of the input word and the exact edges of the accepted range.
        directed.push_back({serial_of(1'b0, 64'd0, 64'd0), 1'b1, EPOCH_DATE});
        directed.push_back({48'h7FFF_FFFF_FFFF, 1'b1, NO_DATE});
        directed.push_back({48'h8000_0000_0000, 1'b1, NO_DATE});
        directed.push_back({serial_of(1'b0, 64'(MAX_DAYS), 64'd0), 1'b1, LAST_DATE});
        directed.push_back({serial_of(1'b0, 64'(MAX_DAYS), 64'd1), 1'b1, NO_DATE});
        directed.push_back({serial_of(1'b0, 64'(MAX_DAYS), FMASK), 1'b1, NO_DATE});
        directed.push_back({serial_of(1'b1, 64'(MIN_DAYS), 64'd0), 1'b1, FIRST_DATE});
        directed.push_back({serial_of(1'b1, 64'(MIN_DAYS), 64'd1), 1'b1, NO_DATE});
        directed.push_back({serial_of(1'b1, 64'(MIN_DAYS) - 64'd1, FMASK), 1'b0, NO_DATE});
        // No whole days, negative: the epoch day, time taken from the magnitude; the last rounds to the day before.
        directed.push_back({serial_of(1'b1, 64'd0, 64'd1), 1'b0, NO_DATE});
        directed.push_back({serial_of(1'b1, 64'd0, HALF_DAY), 1'b0, NO_DATE});
        directed.push_back({serial_of(1'b1, 64'd0, FMASK), 1'b0, NO_DATE});
        // Rounding that carries into the next day.
        directed.push_back({serial_of(1'b0, 64'd0, FMASK), 1'b0, NO_DATE});
        directed.push_back({serial_of(1'b0, 64'(MAX_DAYS) - 64'd1, FMASK - 64'd40),
                            1'b0, NO_DATE});
        // Leap day 2000, also reached by a rounding carry, and the day after; leap day 1904; 1900, which has none.
        directed.push_back({serial_of(1'b0, 64'd36584, FMASK - 64'd50), 1'b0, NO_DATE});
        directed.push_back({serial_of(1'b0, 64'd36585, 64'd0), 1'b0, NO_DATE});
        directed.push_back({serial_of(1'b0, 64'd36586, 64'd0), 1'b0, NO_DATE});
        directed.push_back({serial_of(1'b0, 64'd1521, HALF_DAY), 1'b0, NO_DATE});
        directed.push_back({serial_of(1'b0, 64'd60, 64'd0), 1'b0, NO_DATE});
        directed.push_back({serial_of(1'b0, 64'd61, 64'd0), 1'b0, NO_DATE});
        // Last day of a leap year, and the starts of a 400-year block and of a century.
        directed.push_back({serial_of(1'b0, 64'd36891, FMASK >> 1), 1'b0, NO_DATE});
        directed.push_back({serial_of(1'b1, 64'd109571, 64'd0), 1'b0, NO_DATE});
        directed.push_back({serial_of(1'b1, 64'd73046, 64'd0), 1'b0, NO_DATE});
        directed.push_back({serial_of(1'b0, 64'd45000, 64'd12345678), 1'b0, NO_DATE});

        for (i = 0; i < directed.size(); i++)
            send_date(directed[i].sd, directed[i].lit_on, directed[i].lit);

        // Random dates. Most lie in range, a share sits on calendar and rounding edges, and
        // the rest is raw noise or values just outside the limits.
        for (i = 0; i < RANDOM_DATES; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 50)
            begin
                // Anywhere in range, positive more often than negative.
                neg = ($urandom_range(0, 3) == 0);
                if (neg)
                    days = 64'($urandom_range(0, int'(MIN_DAYS) - 1));
                else
                    days = 64'($urandom_range(0, int'(MAX_DAYS) - 1));
                frac = 64'($urandom) & FMASK;
                sd   = serial_of(neg, days, frac);
            end
            else if (kind < 70)
            begin
                // Near a cycle boundary or the leap day, by building the absolute day count
                // from 400-year, century, four-year and year steps.
                wide = 64'($urandom_range(1, 24)) * 64'd146097
                     + 64'($urandom_range(0, 3)) * 64'd36524
                     + 64'($urandom_range(0, 24)) * 64'd1461
                     + 64'($urandom_range(0, 3)) * 64'd365;
                case ($urandom_range(0, 4))
                    0:       wide = wide;
                    1:       wide = wide + 64'd1;
                    2:       wide = wide + 64'd58 + 64'($urandom_range(0, 3));
                    3:       wide = wide + 64'd364 + 64'($urandom_range(0, 2));
                    default: wide = wide + 64'($urandom_range(0, 365));
                endcase
                signed_days = longint'(wide) - EPOCH_ABS;
                neg  = (signed_days < 0);
                days = neg ? 64'(-signed_days) : 64'(signed_days);
                case ($urandom_range(0, 2))
                    0:       frac = 64'd0;
                    1:       frac = FMASK;
                    default: frac = 64'($urandom) & FMASK;
                endcase
                sd = serial_of(neg, days, frac);
            end
            else if (kind < 85)
            begin
                // Fractions close to the day boundary or to a whole second.
                neg  = ($urandom_range(0, 3) == 0);
                days = neg ? 64'($urandom_range(0, int'(MIN_DAYS) - 1))
                           : 64'($urandom_range(0, int'(MAX_DAYS) - 1));
                case ($urandom_range(0, 2))
                    0:       frac = FMASK - 64'($urandom_range(0, 120));
                    1:       frac = 64'($urandom_range(0, 200));
                    default: frac = ((64'($urandom_range(1, 86399)) << FB) / 64'd86400)
                                  + 64'($urandom_range(0, 200)) - 64'd100;
                endcase
                sd = serial_of(neg, days, frac);
            end
            else if (kind < 93)
            begin
                // Every bit of the word at random, which is out of range more often than not.
                wide = {$urandom, $urandom};
                sd   = wide[47:0];
            end
            else
            begin
                // Just past one of the two limits.
                wide = 64'($urandom_range(1, 1 << 30));
                if ($urandom_range(0, 1) == 0)
                    sd = 48'(HI_LIMIT + wide);
                else
                    sd = ~48'(LO_LIMIT + wide) + 48'd1;
            end
            send_date(sd, 1'b0, NO_DATE);
        end

        // Drain: every result must come out, then the bench waits on to catch extra strobes.
        start <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d dates: %0d in range, %0d rejected, %0d leap days among them.",
                 checked_dates, in_range_dates, rejected_dates, leap_days_seen);
        $display("%0d mismatching or unexpected results in %0d cycles.", mismatches, cycles);
        if (mismatches == 0 && pending_dates.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
